>>> hw/rtl/textured_wall_column_scaler_core_defines.svh
// ----------------------------------------------------------------------------
// textured wall column scaler - assertion macros
// shared concurrent assertion forms for the column scaler rtl
// ----------------------------------------------------------------------------
`ifndef TEXTURED_WALL_COLUMN_SCALER_CORE_DEFINES_SVH
`define TEXTURED_WALL_COLUMN_SCALER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TWCS_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define TWCS_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/twcs_pkg.sv
// ----------------------------------------------------------------------------
// twcs_pkg
// types, widths and constants shared by the column scaler modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package twcs_pkg;

	localparam int TEX_SIZE_DEF    = 64;
	localparam int SCREEN_ROWS_DEF = 512;

	localparam int COL_W  = 10;
	localparam int TCOL_W = 6;
	localparam int HW     = 24;
	localparam int SY_W   = 9;
	localparam int TY_W   = 7;

	localparam int STEP_W  = 31;
	localparam int ACC_W   = 23;
	localparam int TY_LSB  = 16;
	localparam int WT_FRAC = 9;
	localparam int ALU_W   = 32;

	localparam logic [STEP_W-1:0] STEP_MAX = '1;
	localparam logic [ACC_W-1:0]  ACC_MAX  = '1;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_LOAD
	} setup_state_t;

	typedef struct packed {
		logic             sub;
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic              load;
		logic [STEP_W-1:0] step;
		logic [ACC_W-1:0]  acc;
		logic [HW-1:0]     height;
	} setup_res_t;

	typedef struct packed {
		logic start;
		logic tick;
	} pix_ctrl_t;

endpackage

>>> hw/rtl/twcs_alu.sv
// ----------------------------------------------------------------------------
// twcs_alu
// shared add / subtract unit used by the divide and multiply sequences
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module twcs_alu (
	input  twcs_pkg::alu_req_t          req,
	output logic [twcs_pkg::ALU_W:0]    sum
);
	import twcs_pkg::*;

	logic [ALU_W-1:0] b_x;

	// carry out of a subtract means a >= b
	assign b_x = req.b ^ {ALU_W{req.sub}};
	assign sum = {1'b0, req.a} + {1'b0, b_x} + (ALU_W + 1)'(req.sub);

endmodule

>>> hw/rtl/twcs_setup.sv
// ----------------------------------------------------------------------------
// twcs_setup
// per-column sequencer: restoring divide for the texture step, shift-add
// multiply for the clipped start texture offset, both on the shared alu
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module twcs_setup #(
	parameter int TEX_SIZE    = twcs_pkg::TEX_SIZE_DEF,
	parameter int SCREEN_ROWS = twcs_pkg::SCREEN_ROWS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [twcs_pkg::HW-1:0]   height,
	output logic                      busy,
	output twcs_pkg::setup_res_t      res
);
	import twcs_pkg::*;

	localparam int DVW = $clog2(TEX_SIZE + 1) + HW;
	localparam int CW  = $clog2(DVW);
	localparam int QXW = (DVW > STEP_W) ? DVW : STEP_W + 1;
	localparam logic [DVW-1:0] DIVIDEND = DVW'(TEX_SIZE) << HW;
	localparam logic [HW-1:0]  LIMIT    = HW'(SCREEN_ROWS * 256);

	setup_state_t state_q, state_d;
	logic [CW-1:0]     cnt_q;
	logic [HW-1:0]     h_q;
	logic              clip_q;
	logic [HW-1:0]     rem_q;
	logic [DVW-1:0]    q_q;
	logic [STEP_W-1:0] hi_q;
	logic [HW-1:0]     lo_q;

	alu_req_t          req;
	logic [ALU_W:0]    sum;
	logic [HW:0]       rem_sh;
	logic              div_ge;
	logic              div_last;
	logic              mul_last;
	logic [QXW-1:0]    q_ext;
	logic [STEP_W-1:0] step_sat;
	logic [STEP_W:0]   mul_s;

	twcs_alu u_alu (
		.req (req),
		.sum (sum)
	);

	assign rem_sh   = {rem_q, q_q[DVW-1]};
	assign div_ge   = sum[ALU_W];
	assign div_last = (cnt_q == CW'(DVW - 1));
	assign mul_last = (cnt_q == CW'(HW - 1));
	assign q_ext    = QXW'(q_q);
	assign step_sat = (q_ext > QXW'(STEP_MAX)) ? STEP_MAX : q_ext[STEP_W-1:0];
	assign mul_s    = lo_q[0] ? sum[STEP_W:0] : {1'b0, hi_q};

	always_comb begin
		if (state_q == ST_MUL) begin
			req.sub = 1'b0;
			req.a   = {1'b0, hi_q};
			req.b   = {1'b0, step_sat};
		end else begin
			req.sub = 1'b1;
			req.a   = ALU_W'(rem_sh);
			req.b   = ALU_W'(h_q);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start && (height != '0))
					state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_last)
					state_d = clip_q ? ST_MUL : ST_LOAD;
			end
			ST_MUL: begin
				if (mul_last)
					state_d = ST_LOAD;
			end
			ST_LOAD: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy     = 1'b1;
		res.load = 1'b0;
		case (state_q)
			ST_IDLE: busy = 1'b0;
			ST_LOAD: res.load = 1'b1;
			default: busy = 1'b1;
		endcase
		// product sits in {hi, lo}; start texture offset is product >> 9, saturated to 23 bits
		res.step   = step_sat;
		res.height = clip_q ? LIMIT : h_q;
		if (!clip_q)
			res.acc = '0;
		else if (hi_q[STEP_W-1:8] != '0)
			res.acc = ACC_MAX;
		else
			res.acc = {hi_q[7:0], lo_q[HW-1:9]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_DIV && div_last) || (state_q == ST_MUL && mul_last)
					|| state_q == ST_IDLE)
				cnt_q <= '0;
			else
				cnt_q <= cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					h_q    <= height;
					clip_q <= (height > LIMIT);
					rem_q  <= '0;
					q_q    <= DIVIDEND;
				end
			end
			ST_DIV: begin
				rem_q <= div_ge ? sum[HW-1:0] : rem_sh[HW-1:0];
				q_q   <= {q_q[DVW-2:0], div_ge};
				if (div_last) begin
					hi_q <= '0;
					lo_q <= h_q - LIMIT;
				end
			end
			ST_MUL: begin
				hi_q <= mul_s[STEP_W:1];
				lo_q <= {mul_s[0], lo_q[HW-1:1]};
			end
			default: begin
			end
		endcase
	end

endmodule

>>> hw/rtl/twcs_pixel.sv
// ----------------------------------------------------------------------------
// twcs_pixel
// column state and per-tick pixel stepping with the output word register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module twcs_pixel #(
	parameter int TEX_SIZE    = twcs_pkg::TEX_SIZE_DEF,
	parameter int SCREEN_ROWS = twcs_pkg::SCREEN_ROWS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  twcs_pkg::pix_ctrl_t           ctrl,
	input  logic [twcs_pkg::COL_W-1:0]    column_x,
	input  logic [twcs_pkg::TCOL_W-1:0]   texture_column,
	input  twcs_pkg::setup_res_t          res,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic [twcs_pkg::COL_W-1:0]    screen_x,
	output logic [twcs_pkg::SY_W-1:0]     screen_y,
	output logic [twcs_pkg::TCOL_W-1:0]   texel_x,
	output logic [twcs_pkg::TY_W-1:0]     texel_y,
	output logic                          texel_outside,
	output logic                          last_row
);
	import twcs_pkg::*;

	localparam int RW   = $clog2(SCREEN_ROWS + 1);
	localparam int WTW  = $clog2(SCREEN_ROWS * 256);
	localparam int SUMW = RW + WTW;
	localparam logic [HW-1:0] LIMIT = HW'(SCREEN_ROWS * 256);

	logic              busy_q;
	logic [RW-1:0]     row_q;
	logic [RW-1:0]     rows_q;
	logic [WTW-1:0]    wall_top_q;
	logic [ACC_W-1:0]  acc_q;
	logic [STEP_W-1:0] step_q;
	logic [COL_W-1:0]  col_q;
	logic [TCOL_W-1:0] tcol_q;

	logic              out_valid_q;
	logic [COL_W-1:0]  screen_x_q;
	logic [SY_W-1:0]   screen_y_q;
	logic [TCOL_W-1:0] texel_x_q;
	logic [TY_W-1:0]   texel_y_q;
	logic              texel_outside_q;
	logic              last_row_q;

	logic              emit;
	logic              last;
	logic [TY_W-1:0]   ty;
	logic [SUMW-1:0]   y_sum;
	logic [STEP_W:0]   acc_sum;
	logic [ACC_W-1:0]  acc_next;
	logic [HW:0]       rows_sum;

	assign emit     = ctrl.tick && busy_q;
	assign ty       = acc_q[ACC_W-1:TY_LSB];
	assign last     = ((RW + 1)'(row_q) + (RW + 1)'(1)) >= (RW + 1)'(rows_q);
	assign y_sum    = SUMW'(row_q) + SUMW'(wall_top_q >> WT_FRAC);
	assign acc_sum  = (STEP_W + 1)'(acc_q) + (STEP_W + 1)'(step_q);
	assign acc_next = (acc_sum[STEP_W:ACC_W] != '0) ? ACC_MAX : acc_sum[ACC_W-1:0];
	// rows covered: ceiling of the clipped Q16.8 height
	assign rows_sum = (HW + 1)'(res.height) + (HW + 1)'(255);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			row_q  <= '0;
		end else if (ctrl.start) begin
			busy_q <= 1'b0;
			row_q  <= '0;
		end else if (res.load) begin
			busy_q <= 1'b1;
			row_q  <= '0;
		end else if (emit) begin
			if (last) begin
				busy_q <= 1'b0;
				row_q  <= '0;
			end else begin
				row_q <= row_q + RW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			col_q  <= column_x;
			tcol_q <= texture_column;
		end
		if (res.load) begin
			step_q     <= res.step;
			acc_q      <= res.acc;
			wall_top_q <= WTW'(LIMIT - res.height);
			rows_q     <= RW'(rows_sum >> 8);
		end else if (emit) begin
			acc_q <= acc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			screen_x_q      <= col_q;
			screen_y_q      <= y_sum[SY_W-1:0];
			texel_x_q       <= tcol_q;
			texel_y_q       <= ty;
			texel_outside_q <= ({2'b00, ty} > (TY_W + 2)'(TEX_SIZE - 1));
			last_row_q      <= last;
		end
	end

	assign out_valid     = out_valid_q;
	assign screen_x      = screen_x_q;
	assign screen_y      = screen_y_q;
	assign texel_x       = texel_x_q;
	assign texel_y       = texel_y_q;
	assign texel_outside = texel_outside_q;
	assign last_row      = last_row_q;

endmodule

>>> hw/rtl/textured_wall_column_scaler_core.sv
// ----------------------------------------------------------------------------
// textured_wall_column_scaler_core
// raycaster wall slice scaler: per-column setup, then one pixel word per tick
// ----------------------------------------------------------------------------
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_stall   | cmd, column_x, texture_column, wall_height
// out     | output    | out_valid / out_stall | screen_x, screen_y, texel_x, texel_y,
//         |           |                       | texel_outside, last_row
//
// a start word with nonzero height holds in_stall through the divide, then the
// multiply for a clipped wall, then the load state; both loops run on the
// single shared add / subtract unit
// a tick word yields one pixel word while the column is open
// in_stall also rises while a finished pixel word waits under out_stall
// reset clears the sequencer, the column state and the output valid
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "textured_wall_column_scaler_core_defines.svh"

module textured_wall_column_scaler_core #(
	parameter int TEX_SIZE    = twcs_pkg::TEX_SIZE_DEF,
	parameter int SCREEN_ROWS = twcs_pkg::SCREEN_ROWS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          cmd,
	input  logic [twcs_pkg::COL_W-1:0]    column_x,
	input  logic [twcs_pkg::TCOL_W-1:0]   texture_column,
	input  logic [twcs_pkg::HW-1:0]       wall_height,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [twcs_pkg::COL_W-1:0]    screen_x,
	output logic [twcs_pkg::SY_W-1:0]     screen_y,
	output logic [twcs_pkg::TCOL_W-1:0]   texel_x,
	output logic [twcs_pkg::TY_W-1:0]     texel_y,
	output logic                          texel_outside,
	output logic                          last_row
);
	import twcs_pkg::*;

	logic       st_busy;
	logic       in_acc;
	setup_res_t res;
	pix_ctrl_t  ctrl;

	assign in_stall = st_busy || (out_valid && out_stall);
	assign in_acc   = in_valid && !in_stall;
	// start sits in the upper bit, tick in the lower
	assign ctrl     = {in_acc && (cmd == CMD_START), in_acc && (cmd == CMD_TICK)};

	twcs_setup #(
		.TEX_SIZE    (TEX_SIZE),
		.SCREEN_ROWS (SCREEN_ROWS)
	) u_setup (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctrl.start),
		.height (wall_height),
		.busy   (st_busy),
		.res    (res)
	);

	twcs_pixel #(
		.TEX_SIZE    (TEX_SIZE),
		.SCREEN_ROWS (SCREEN_ROWS)
	) u_pixel (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.column_x       (column_x),
		.texture_column (texture_column),
		.res            (res),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.screen_x       (screen_x),
		.screen_y       (screen_y),
		.texel_x        (texel_x),
		.texel_y        (texel_y),
		.texel_outside  (texel_outside),
		.last_row       (last_row)
	);

	`TWCS_ASSERT_NXT(a_start_holds_stall, clk, arst_n, ctrl.start && (wall_height != '0), in_stall, "start word did not stall input")
	`TWCS_ASSERT_NXT(a_zero_height_idle, clk, arst_n, ctrl.start && (wall_height == '0), !st_busy, "zero height start began setup")
	`TWCS_ASSERT_IMP(a_word_from_tick, clk, arst_n, $rose(out_valid), $past(ctrl.tick), "pixel word without a tick")

endmodule

>>> bench/tb_textured_wall_column_scaler_core.sv
// ----------------------------------------------------------------------------
// tb_textured_wall_column_scaler_core
// drives start and tick words into the column scaler under random gaps and
// output stalls, predicts every pixel word of each wall slice and checks the
// pixel stream field by field in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_textured_wall_column_scaler_core;

	import twcs_pkg::*;

	localparam int          TEXELS      = TEX_SIZE_DEF;
	localparam int          SCREEN_H    = SCREEN_ROWS_DEF;
	localparam bit [63:0]   CLIP_Q8     = 64'(SCREEN_ROWS_DEF) << 8;
	localparam int          RANDOM_WORDS = 700;
	localparam int          CYCLE_LIMIT = 500000;
	localparam int          TAIL_CYCLES = 200;

	typedef struct packed {
		logic [COL_W-1:0]  sx;
		logic [SY_W-1:0]   sy;
		logic [TCOL_W-1:0] tx;
		logic [TY_W-1:0]   ty;
		logic              outside;
		logic              last;
	} pixel_t;

	class column_scoreboard;
		logic               busy;
		logic [9:0]         row_idx;
		logic [9:0]         row_count;
		logic [16:0]        top_q9;
		logic [ACC_W-1:0]   tex_acc;
		logic [STEP_W-1:0]  tex_inc;
		logic [COL_W-1:0]   col_hold;
		logic [TCOL_W-1:0]  tcol_hold;
		pixel_t             expected_pixels[$];
		int                 errors;

		function new();
			busy = 1'b0;
			row_idx = '0;
			row_count = '0;
			top_q9 = '0;
			tex_acc = '0;
			tex_inc = '0;
			col_hold = '0;
			tcol_hold = '0;
			errors = 0;
		endfunction

		function int waiting();
			return expected_pixels.size();
		endfunction

		function string pixel_str(pixel_t p);
			return $sformatf("x=%0d y=%0d tx=%0d ty=%0d out=%0d last=%0d",
				p.sx, p.sy, p.tx, p.ty, p.outside, p.last);
		endfunction

		function void note_word(logic c, logic [COL_W-1:0] col, logic [TCOL_W-1:0] tcol,
				logic [HW-1:0] h);
			bit [63:0] hq;
			bit [63:0] step;
			bit [63:0] sum;
			pixel_t    p;
			logic      last;

			if (c == CMD_START) begin
				col_hold = col;
				tcol_hold = tcol;
				row_idx = '0;
				tex_acc = '0;
				hq = 64'(h);
				if (hq == 0) begin
					busy = 1'b0;
					row_count = '0;
					tex_inc = '0;
					top_q9 = '0;
					return;
				end
				step = (64'(TEXELS) << 24) / hq;
				if (step > 64'(STEP_MAX))
					step = 64'(STEP_MAX);
				tex_inc = step[STEP_W-1:0];
				if (hq > CLIP_Q8) begin
					// centred texture offset, half of the overshoot in q.9
					sum = ((hq - CLIP_Q8) * step) >> 9;
					tex_acc = (sum > 64'(ACC_MAX)) ? ACC_MAX : sum[ACC_W-1:0];
					hq = CLIP_Q8;
				end
				sum = ((64'(SCREEN_H) / 2) << 9) - hq;
				top_q9 = sum[16:0];
				sum = (hq + 64'd255) >> 8;
				row_count = sum[9:0];
				busy = 1'b1;
			end else if (busy) begin
				last = (int'(row_idx) + 1 >= int'(row_count));
				p.sx = col_hold;
				sum = 64'(row_idx) + 64'(top_q9 >> 9);
				p.sy = sum[SY_W-1:0];
				p.tx = tcol_hold;
				p.ty = tex_acc[ACC_W-1:TY_LSB];
				p.outside = (int'(p.ty) > TEXELS - 1);
				p.last = last;
				expected_pixels.push_back(p);
				sum = 64'(tex_acc) + 64'(tex_inc);
				tex_acc = (sum > 64'(ACC_MAX)) ? ACC_MAX : sum[ACC_W-1:0];
				row_idx = row_idx + 10'd1;
				if (last) begin
					busy = 1'b0;
					row_idx = '0;
				end
			end
		endfunction

		function void check_pixel(pixel_t got);
			pixel_t want;

			if (expected_pixels.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected pixel word: %s", pixel_str(got));
				return;
			end
			want = expected_pixels.pop_front();
			if (got.sx !== want.sx || got.sy !== want.sy || got.tx !== want.tx ||
					got.ty !== want.ty || got.outside !== want.outside ||
					got.last !== want.last) begin
				errors++;
				if (errors <= 10)
					$display("pixel mismatch: expected %s, actual %s",
						pixel_str(want), pixel_str(got));
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               cmd;
	logic [COL_W-1:0]   column_x;
	logic [TCOL_W-1:0]  texture_column;
	logic [HW-1:0]      wall_height;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [COL_W-1:0]   screen_x;
	logic [SY_W-1:0]    screen_y;
	logic [TCOL_W-1:0]  texel_x;
	logic [TY_W-1:0]    texel_y;
	logic               texel_outside;
	logic               last_row;

	column_scoreboard   sb = new();
	int                 cycles = 0;
	int                 words_sent = 0;
	logic               calm = 1'b0;

	textured_wall_column_scaler_core uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.column_x       (column_x),
		.texture_column (texture_column),
		.wall_height    (wall_height),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.screen_x       (screen_x),
		.screen_y       (screen_y),
		.texel_x        (texel_x),
		.texel_y        (texel_y),
		.texel_outside  (texel_outside),
		.last_row       (last_row)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// input words are noted before output words, both seen at the same edge
	always @(posedge clk) begin
		pixel_t got;
		if (arst_n) begin
			cycles++;
			if (in_valid && !in_stall)
				sb.note_word(cmd, column_x, texture_column, wall_height);
			if (out_valid && !out_stall) begin
				got.sx = screen_x;
				got.sy = screen_y;
				got.tx = texel_x;
				got.ty = texel_y;
				got.outside = texel_outside;
				got.last = last_row;
				sb.check_pixel(got);
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 20);
	end

	initial begin : watchdog
		while (cycles < CYCLE_LIMIT)
			@(posedge clk);
		$display("simulation failed");
		$finish;
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_word(logic c, logic [COL_W-1:0] col, logic [TCOL_W-1:0] tcol,
			logic [HW-1:0] h);
		while (!calm && $urandom_range(99) < 20) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		column_x <= col;
		texture_column <= tcol;
		wall_height <= h;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic run_column(logic [COL_W-1:0] col, logic [TCOL_W-1:0] tcol,
			logic [HW-1:0] h, int ticks);
		send_word(CMD_START, col, tcol, h);
		repeat (ticks)
			send_word(CMD_TICK, COL_W'($urandom), TCOL_W'($urandom), HW'($urandom));
	endtask

	// hold the sender off until the pixel stream has caught up
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (sb.waiting() > 0);
	endtask

	initial begin
		int seq;
		int r;
		int rows;
		int ticks;
		logic [HW-1:0] h;

		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_START;
		column_x = '0;
		texture_column = '0;
		wall_height = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// tick while idle, zero height, smallest heights, start over a running column
		send_word(CMD_TICK, '1, '1, '1);
		run_column('0, '0, '0, 1);
		run_column('1, '1, 24'd1, 2);
		run_column(10'd512, 6'd32, 24'd256, 1);
		run_column(10'd7, 6'd1, 24'd640, 3);
		run_column(10'd100, 6'd20, CLIP_Q8[HW-1:0], 3);
		run_column(10'd1023, 6'd63, 24'hFFFFFF, 3);
		run_column(10'd3, 6'd62, 24'h020001, 2);
		run_column(10'd0, 6'd0, 24'd300, 3);

		seq = 0;
		while (words_sent < 25 + RANDOM_WORDS) begin
			calm = (seq >= 15 && seq < 25);
			if (seq == 10 || $urandom_range(99) < 4)
				drain();
			r = $urandom_range(99);
			if (r < 55)
				h = HW'($urandom_range(24 * 256, 1));
			else if (r < 70)
				h = HW'($urandom_range(767, 1));
			else if (r < 76)
				h = HW'($urandom_range(int'(CLIP_Q8), 1));
			else if (r < 80)
				h = HW'(int'(CLIP_Q8) + $urandom_range(2) - 1);
			else if (r < 90)
				h = HW'($urandom_range(24'hFFFFFF, int'(CLIP_Q8) + 1));
			else
				h = '0;
			rows = (int'(h) > int'(CLIP_Q8)) ? SCREEN_H : (int'(h) + 255) >> 8;
			if ($urandom_range(99) < 75)
				ticks = rows + $urandom_range(2);
			else
				ticks = $urandom_range(rows);
			// tall slices are mostly cut short to keep the run brief
			if (rows > 64 && $urandom_range(3) != 0)
				ticks = $urandom_range(40, 1);
			if ($urandom_range(99) < 5)
				send_word(CMD_TICK, COL_W'($urandom), TCOL_W'($urandom), HW'($urandom));
			run_column(COL_W'($urandom), TCOL_W'($urandom), h, ticks);
			seq++;
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		while (sb.waiting() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.waiting() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
